/* hdl/sawfs_pkg.sv */
// Shared types, codes and helpers for the stop-and-wait frame sender.
// No dependencies; used by sawfs_front, sawfs_back and the top level.
`default_nettype none

package sawfs_pkg;

  // Item selector carried on the slave tuser
  typedef enum logic [1:0] {
    FUNC_DATA = 2'd0,
    FUNC_ACK  = 2'd1,
    FUNC_TICK = 2'd2,
    FUNC_SLOT = 2'd3
  } func_e;

  // Configuration register indexes
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_MAXPAY  = 1'b1;

  localparam logic [15:0] TIMEOUT_RST = 16'd1000;
  localparam logic [13:0] MAXPAY_RST  = 14'd5000;

  localparam logic [7:0] KIND_ACK   = 8'h06;
  localparam logic [7:0] KIND_FINAL = 8'h08;
  localparam logic [7:0] KIND_MORE  = 8'h09;
  localparam logic [7:0] SUM_GOOD   = 8'hFF;

  // Result queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QW          = $clog2(QUEUE_DEPTH);

  // Per-beat descriptor handed from front to back
  typedef struct packed {
    logic       tx_valid;
    logic       use_ram;
    logic [7:0] hdr_byte;
    logic       frame_end;
    logic       acked;
    logic       resend;
    logic       ready;
    logic [7:0] seq;
  } desc_t;

  // Finished result held in the queue
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       acked;
    logic       resend;
    logic       ready;
    logic [7:0] seq;
  } result_t;

  // Back-end occupancy reported to the front
  typedef struct packed {
    logic [QW:0] count;
  } back_status_t;

  // 8-bit end-around-carry add
  function automatic logic [7:0] fold_byte(input logic [7:0] s, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, s} + {1'b0, b};
    fold_byte = t[7:0] + {7'd0, t[8]};
  endfunction

endpackage

`default_nettype wire

/* hdl/sawfs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sawfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hdl/sawfs_front.sv */
// Front end: accepts beats, runs the load/send/wait control, builds frame
// headers and drives the payload RAM ports. Depends on sawfs_pkg.
`default_nettype none

module sawfs_front #(
  parameter int PACKET_BYTES = 8192
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // input beats
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire sawfs_pkg::func_e             func_i,
  input  wire logic [7:0]                   data_byte_i,
  input  wire logic                         message_last_i,
  input  wire logic [7:0]                   ack_check_i,
  input  wire logic [7:0]                   ack_kind_i,
  input  wire logic [7:0]                   ack_number_i,
  // configuration
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_idx_i,
  input  wire logic [15:0]                  cfg_wdata_i,
  // payload RAM
  output logic                              ram_we_o,
  output logic [$clog2(PACKET_BYTES)-1:0]   ram_waddr_o,
  output logic [7:0]                        ram_wdata_o,
  output logic                              ram_re_o,
  output logic [$clog2(PACKET_BYTES)-1:0]   ram_raddr_o,
  // to back end
  output logic                              desc_valid_o,
  output sawfs_pkg::desc_t                  desc_o,
  input  wire sawfs_pkg::back_status_t      status_i
);

  localparam int AW = $clog2(PACKET_BYTES);
  localparam int CW = $clog2(PACKET_BYTES + 1);
  localparam int IW = $clog2(PACKET_BYTES + 5);
  localparam int LW = (CW > 14) ? CW : 14;
  localparam int QW_T = sawfs_pkg::QW + 1;

  typedef enum logic [1:0] {
    PH_LOAD,
    PH_SEND,
    PH_WAIT
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       seq_q, seq_d;
  logic [IW-1:0]    tx_idx_q, tx_idx_d;
  logic [16:0]      timer_q, timer_d;
  logic             final_q, final_d;
  logic [15:0]      timeout_q;
  logic [13:0]      maxpay_q;
  logic             desc_valid_q;
  sawfs_pkg::desc_t desc_q, desc_d;

  logic             accept;
  logic [QW_T-1:0]  occ;

  logic [LW-1:0]    lim, mp;
  logic [CW-1:0]    fill_inc;
  logic [2:0]       head;
  logic [IW-1:0]    flen, idx_inc;
  logic [7:0]       kind, len_byte, chk, s2, s3, ack_sum;
  logic [16:0]      timer_inc;
  logic             ack_ok;

  // a slot is free when queued plus in-flight beats leave room
  assign occ        = status_i.count + QW_T'(desc_valid_q);
  assign in_ready_o = (occ < QW_T'(sawfs_pkg::QUEUE_DEPTH));
  assign accept     = in_valid_i && in_ready_o;

  assign mp  = LW'(maxpay_q);
  assign lim = (mp == '0) ? LW'(1) :
               (mp > LW'(PACKET_BYTES)) ? LW'(PACKET_BYTES) : mp;

  assign fill_inc = fill_q + CW'(1);
  assign head     = final_q ? 3'd4 : 3'd3;
  assign flen     = IW'(fill_q) + IW'(head);
  assign idx_inc  = tx_idx_q + IW'(1);

  // header checksum from current state
  assign kind     = final_q ? sawfs_pkg::KIND_FINAL : sawfs_pkg::KIND_MORE;
  assign len_byte = 8'(fill_q);
  assign s2       = sawfs_pkg::fold_byte(kind, seq_q);
  assign s3       = final_q ? sawfs_pkg::fold_byte(s2, len_byte) : s2;
  assign chk      = ~sawfs_pkg::fold_byte(s3, sum_q);

  assign ack_sum = sawfs_pkg::fold_byte(sawfs_pkg::fold_byte(ack_check_i, ack_kind_i),
                                        ack_number_i);
  assign ack_ok  = (ack_sum == sawfs_pkg::SUM_GOOD) && (ack_kind_i == sawfs_pkg::KIND_ACK) &&
                   (ack_number_i == seq_q);

  assign timer_inc = (timer_q != '1) ? timer_q + 17'd1 : timer_q;

  always_comb begin
    phase_d  = phase_q;
    fill_d   = fill_q;
    sum_d    = sum_q;
    seq_d    = seq_q;
    tx_idx_d = tx_idx_q;
    timer_d  = timer_q;
    final_d  = final_q;
    ram_we_o = 1'b0;
    ram_re_o = 1'b0;
    desc_d   = '0;

    case (func_i)
      sawfs_pkg::FUNC_DATA: begin
        if (phase_q == PH_LOAD) begin
          if (fill_q < CW'(PACKET_BYTES)) begin
            ram_we_o = accept;
            fill_d   = fill_inc;
            sum_d    = sawfs_pkg::fold_byte(sum_q, data_byte_i);
          end
          if (message_last_i || (LW'(fill_d) >= lim)) begin
            final_d  = message_last_i;
            phase_d  = PH_SEND;
            tx_idx_d = '0;
          end
        end
      end
      sawfs_pkg::FUNC_ACK: begin
        if (phase_q == PH_WAIT) begin
          tx_idx_d = '0;
          if (ack_ok) begin
            desc_d.acked = 1'b1;
            seq_d        = seq_q + 8'd1;
            phase_d      = PH_LOAD;
            fill_d       = '0;
            sum_d        = '0;
            final_d      = 1'b0;
          end else begin
            desc_d.resend = 1'b1;
            phase_d       = PH_SEND;
          end
        end
      end
      sawfs_pkg::FUNC_TICK: begin
        if (phase_q == PH_WAIT) begin
          timer_d = timer_inc;
          if (timer_inc > {1'b0, timeout_q}) begin
            desc_d.resend = 1'b1;
            phase_d       = PH_SEND;
            tx_idx_d      = '0;
          end
        end
      end
      sawfs_pkg::FUNC_SLOT: begin
        if (phase_q == PH_SEND) begin
          desc_d.tx_valid = 1'b1;
          if (tx_idx_q == IW'(0)) begin
            desc_d.hdr_byte = chk;
          end else if (tx_idx_q == IW'(1)) begin
            desc_d.hdr_byte = kind;
          end else if (tx_idx_q == IW'(2)) begin
            desc_d.hdr_byte = seq_q;
          end else if (tx_idx_q == IW'(3) && final_q) begin
            desc_d.hdr_byte = len_byte;
          end else begin
            desc_d.use_ram = 1'b1;
            ram_re_o       = accept;
          end
          if (idx_inc >= flen) begin
            desc_d.frame_end = 1'b1;
            phase_d          = PH_WAIT;
            timer_d          = '0;
            tx_idx_d         = '0;
          end else begin
            tx_idx_d = idx_inc;
          end
        end
      end
      default: ;
    endcase

    desc_d.ready = (phase_d == PH_LOAD);
    desc_d.seq   = seq_d;
  end

  assign ram_waddr_o = AW'(fill_q);
  assign ram_wdata_o = data_byte_i;
  assign ram_raddr_o = AW'(tx_idx_q - IW'(head));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_LOAD;
      fill_q       <= '0;
      sum_q        <= '0;
      seq_q        <= '0;
      tx_idx_q     <= '0;
      timer_q      <= '0;
      final_q      <= 1'b0;
      timeout_q    <= sawfs_pkg::TIMEOUT_RST;
      maxpay_q     <= sawfs_pkg::MAXPAY_RST;
      desc_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sawfs_pkg::REG_TIMEOUT: timeout_q <= cfg_wdata_i;
          sawfs_pkg::REG_MAXPAY:  maxpay_q  <= cfg_wdata_i[13:0];
          default: ;
        endcase
      end
      desc_valid_q <= accept;
      if (accept) begin
        phase_q  <= phase_d;
        fill_q   <= fill_d;
        sum_q    <= sum_d;
        seq_q    <= seq_d;
        tx_idx_q <= tx_idx_d;
        timer_q  <= timer_d;
        final_q  <= final_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      desc_q <= desc_d;
    end
  end

  assign desc_valid_o = desc_valid_q;
  assign desc_o       = desc_q;

endmodule

`default_nettype wire

/* hdl/sawfs_back.sv */
// Back end: merges descriptors with payload RAM read data and queues the
// finished results for the master stream. Depends on sawfs_pkg.
`default_nettype none

module sawfs_back (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     desc_valid_i,
  input  wire sawfs_pkg::desc_t         desc_i,
  input  wire logic [7:0]               ram_rdata_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output sawfs_pkg::result_t            result_o,
  output sawfs_pkg::back_status_t       status_o
);

  localparam int QW = sawfs_pkg::QW;

  sawfs_pkg::result_t entry_q [sawfs_pkg::QUEUE_DEPTH];
  sawfs_pkg::result_t res_in;
  logic [QW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [QW:0]        count_q;
  logic               push, pop;

  always_comb begin
    res_in.tx_valid  = desc_i.tx_valid;
    res_in.tx_byte   = desc_i.use_ram ? ram_rdata_i : desc_i.hdr_byte;
    res_in.frame_end = desc_i.frame_end;
    res_in.acked     = desc_i.acked;
    res_in.resend    = desc_i.resend;
    res_in.ready     = desc_i.ready;
    res_in.seq       = desc_i.seq;
  end

  assign push = desc_valid_i;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QW'(1);
      end
      count_q <= count_q + (QW+1)'(push) - (QW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= res_in;
    end
  end

  assign out_valid_o    = (count_q != '0);
  assign result_o       = entry_q[rd_ptr_q];
  assign status_o.count = count_q;

endmodule

`default_nettype wire

/* hdl/stop_and_wait_frame_sender_core.sv */
// Stop-and-wait frame sender: top level.
// Instantiates sawfs_front, sawfs_ram and sawfs_back; uses sawfs_pkg.
//
// Usage:
//   Slave stream: one beat per item. tuser selects payload byte, ack arrival,
//   timer tick or transmit slot; tlast flags the final message byte; tdata
//   carries the payload byte and the three ack bytes.
//   Master stream: exactly one result beat per accepted input beat, in order.
//   tuser flags a frame byte, tlast marks the last byte of a frame.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0 timeout_ticks, 1 max_payload); the user writes only while the block is idle, which the block does not enforce.
// Timing:
//   One beat accepted per cycle while s_axis_tready is high. A result reaches
//   the master side after the registered control step and payload RAM read,
//   and then after it has entered the result queue.
// Reset:
//   Control state clears at once; the payload RAM is not cleared, as only
//   bytes written for the current packet are ever read. tready is high
//   straight after reset.
// Stall:
//   Results collect in a four-entry queue; s_axis_tready drops when the queue
//   plus the beat in flight fill it, and rises as beats are taken.
`default_nettype none

module stop_and_wait_frame_sender_core #(
  parameter int PACKET_BYTES = 8192
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] data_byte, [15:8] ack_check, [23:16] ack_kind, [31:24] ack_number
  input  wire logic [31:0] s_axis_tdata,
  // [1:0] func
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] tx_byte, [8] packet_acked, [9] resend_started, [10] ready_for_data,
  // [18:11] seq_now, [23:19] zero
  output logic [23:0]      m_axis_tdata,
  // [0] tx_valid
  output logic             m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i
);

  localparam int AW = $clog2(PACKET_BYTES);

  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [7:0]              ram_wdata, ram_rdata;
  logic                    desc_valid;
  sawfs_pkg::desc_t        desc;
  sawfs_pkg::back_status_t status;
  sawfs_pkg::result_t      result;

  sawfs_front #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .func_i         (sawfs_pkg::func_e'(s_axis_tuser)),
    .data_byte_i    (s_axis_tdata[7:0]),
    .message_last_i (s_axis_tlast),
    .ack_check_i    (s_axis_tdata[15:8]),
    .ack_kind_i     (s_axis_tdata[23:16]),
    .ack_number_i   (s_axis_tdata[31:24]),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .desc_valid_o   (desc_valid),
    .desc_o         (desc),
    .status_i       (status)
  );

  sawfs_ram #(
    .WIDTH(8),
    .DEPTH(PACKET_BYTES)
  ) u_ram (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sawfs_back u_back (
    .clk_i,
    .rst_ni,
    .desc_valid_i (desc_valid),
    .desc_i       (desc),
    .ram_rdata_i  (ram_rdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .result_o     (result),
    .status_o     (status)
  );

  assign m_axis_tdata = {5'd0, result.seq, result.ready, result.resend, result.acked,
                         result.tx_byte};
  assign m_axis_tuser = result.tx_valid;
  assign m_axis_tlast = result.frame_end;

  // frame end only ever rides on a frame byte
  a_end_on_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("frame end without frame byte");

  // an ack and a resend never come from the same beat
  a_ack_xor_resend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[8] && m_axis_tdata[9]))
    else $error("ack and resend on one beat");

  // credit scheme keeps the result queue from overflowing
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.count + 3'(desc_valid)) <= 3'(sawfs_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  // a beat in flight always lands in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_valid && !(m_axis_tvalid && m_axis_tready) |=> status.count == $past(status.count) + 3'd1)
    else $error("beat lost between front and back");

endmodule

`default_nettype wire

/* tb/sv/tb_stop_and_wait_frame_sender_core.sv */
`timescale 1ns / 1ps
// Testbench for stop_and_wait_frame_sender_core: random and directed item beats,
// with every result beat predicted by a scoreboard class and checked in order.
// Depends on sawfs_pkg and the core RTL only.

module tb_stop_and_wait_frame_sender_core;
  import sawfs_pkg::*;

  localparam int PACKET_BYTES = 8192;

  typedef enum logic [1:0] {ST_LOAD, ST_SEND, ST_WAIT} tx_phase_e;

  typedef struct packed {
    func_e      func;
    logic [7:0] data;
    logic       last;
    logic [7:0] chk;
    logic [7:0] kind;
    logic [7:0] num;
  } item_t;

  // Tracks the sender state and holds the result beats still to come
  class frame_scoreboard;
    logic [7:0]  pay_mem [PACKET_BYTES];
    int unsigned fill;
    int unsigned tx_pos;
    int unsigned ticks;
    logic [7:0]  pay_sum;
    logic [7:0]  seq;
    tx_phase_e   ph;
    bit          last_pkt;
    logic [15:0] timeout;
    logic [13:0] max_pay;
    result_t     pending_beats[$];
    int          errors;

    function new();
      fill     = 0;
      tx_pos   = 0;
      ticks    = 0;
      pay_sum  = 8'h00;
      seq      = 8'h00;
      ph       = ST_LOAD;
      last_pkt = 1'b0;
      timeout  = TIMEOUT_RST;
      max_pay  = MAXPAY_RST;
      errors   = 0;
    endfunction

    // ones' complement byte add
    function logic [7:0] add_ec(logic [7:0] a, logic [7:0] b);
      logic [8:0] t;
      t = {1'b0, a} + {1'b0, b};
      if (t[8]) t = t - 9'd255;
      return t[7:0];
    endfunction

    function void take_item(item_t it);
      result_t     r;
      int unsigned lim;
      int unsigned hdr;
      logic [7:0]  s;
      logic [7:0]  kind;
      r = '0;
      case (it.func)
        FUNC_DATA: if (ph == ST_LOAD) begin
          if (fill < PACKET_BYTES) begin
            pay_mem[fill] = it.data;
            fill++;
            pay_sum = add_ec(pay_sum, it.data);
          end
          lim = (max_pay == 0) ? 1 : ((max_pay > PACKET_BYTES) ? PACKET_BYTES : max_pay);
          if (it.last || fill >= lim) begin
            last_pkt = it.last;
            ph       = ST_SEND;
            tx_pos   = 0;
          end
        end
        FUNC_ACK: if (ph == ST_WAIT) begin
          s = add_ec(add_ec(it.chk, it.kind), it.num);
          if (s == SUM_GOOD && it.kind == KIND_ACK && it.num == seq) begin
            r.acked  = 1'b1;
            seq      = seq + 8'd1;
            ph       = ST_LOAD;
            fill     = 0;
            pay_sum  = 8'h00;
            last_pkt = 1'b0;
            tx_pos   = 0;
          end else begin
            r.resend = 1'b1;
            ph       = ST_SEND;
            tx_pos   = 0;
          end
        end
        FUNC_TICK: if (ph == ST_WAIT) begin
          if (ticks < 'h1FFFF) ticks++;
          if (ticks > timeout) begin
            r.resend = 1'b1;
            ph       = ST_SEND;
            tx_pos   = 0;
          end
        end
        FUNC_SLOT: if (ph == ST_SEND) begin
          hdr  = last_pkt ? 4 : 3;
          kind = last_pkt ? KIND_FINAL : KIND_MORE;
          r.tx_valid = 1'b1;
          if (tx_pos == 0) begin
            s = add_ec(kind, seq);
            if (last_pkt) s = add_ec(s, 8'(fill));
            s = add_ec(s, pay_sum);
            r.tx_byte = ~s;
          end else if (tx_pos == 1) r.tx_byte = kind;
          else if (tx_pos == 2) r.tx_byte = seq;
          else if (tx_pos == 3 && last_pkt) r.tx_byte = 8'(fill);
          else r.tx_byte = pay_mem[tx_pos - hdr];
          if (tx_pos + 1 >= hdr + fill) begin
            r.frame_end = 1'b1;
            ph          = ST_WAIT;
            ticks       = 0;
            tx_pos      = 0;
          end else begin
            tx_pos++;
          end
        end
        default: ;
      endcase
      r.ready = (ph == ST_LOAD);
      r.seq   = seq;
      pending_beats.push_back(r);
    endfunction

    function string beat_str(result_t r);
      return $sformatf("txv=%0b byte=%02h end=%0b ack=%0b resend=%0b ready=%0b seq=%02h",
                       r.tx_valid, r.tx_byte, r.frame_end, r.acked, r.resend, r.ready,
                       r.seq);
    endfunction

    function void check_beat(result_t got, logic [4:0] pad);
      result_t want;
      if (pending_beats.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected, expected nothing, got %s",
                 $time, beat_str(got));
        return;
      end
      want = pending_beats.pop_front();
      if (got !== want || pad !== 5'd0) begin
        errors++;
        $display("%0t: result mismatch, expected %s pad=00, got %s pad=%02h",
                 $time, beat_str(want), beat_str(got), pad);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_wdata_i;

  frame_scoreboard sb = new();

  int items_sent = 0;
  bit no_idle    = 1'b0;
  bit gap_on     = 1'b1;
  int stall_left = 0;
  bit hold_done  = 1'b0;
  bit rx_busy    = 1'b1;

  stop_and_wait_frame_sender_core #(
    .PACKET_BYTES(PACKET_BYTES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #25_000_000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_beat('{tx_valid: m_axis_tuser, tx_byte: m_axis_tdata[7:0],
                      frame_end: m_axis_tlast, acked: m_axis_tdata[8],
                      resend: m_axis_tdata[9], ready: m_axis_tdata[10],
                      seq: m_axis_tdata[18:11]}, m_axis_tdata[23:19]);
    end
  end

  // Receiver: short random stalls, plus one long hold-off so the block backs up
  initial begin : rx_side
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left == 0 && !no_idle && rst_ni) begin
        if (!hold_done && items_sent >= 120) begin
          stall_left = 80;
          hold_done  = 1'b1;
        end else if (rx_busy && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 11);
        end
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
      if ($urandom_range(0, 99) == 0) rx_busy = !rx_busy;
    end
  end

  function automatic logic [7:0] good_check(logic [7:0] k, logic [7:0] nm);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < 256; i++)
      if (sb.add_ec(sb.add_ec(i[7:0], k), nm) == SUM_GOOD) c = i[7:0];
    return c;
  endfunction

  task automatic push_item(func_e f, logic [7:0] d, logic l, logic [7:0] c, logic [7:0] k,
                           logic [7:0] n);
    int    gap;
    item_t it;
    it = '{f, d, l, c, k, n};
    if ($urandom_range(0, 39) == 0) gap_on = !gap_on;
    if (!no_idle && gap_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tlast  <= l;
    s_axis_tdata  <= {n, k, c, d};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.take_item(it);
    items_sent++;
  endtask

  task automatic push_rand(func_e f);
    push_item(f, 8'($urandom), 1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
              8'($urandom));
  endtask

  // Register writes only once every result beat has come back
  task automatic write_cfg(logic [15:0] tmo, logic [13:0] mp);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_TIMEOUT;
    cfg_wdata_i <= tmo;
    @(negedge clk_i);
    cfg_idx_i   <= REG_MAXPAY;
    cfg_wdata_i <= {2'b00, mp};
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.timeout = tmo;
    sb.max_pay = mp;
  endtask

  task automatic load_packet(int target, bit plain);
    int i;
    i = 0;
    while (sb.ph == ST_LOAD) begin
      if (!plain && $urandom_range(0, 7) == 0) begin
        push_rand(func_e'($urandom_range(1, 3)));
      end else begin
        push_item(FUNC_DATA, 8'($urandom), i >= target - 1, 8'($urandom), 8'($urandom),
                  8'($urandom));
        i++;
      end
    end
  endtask

  task automatic send_frame(bit plain);
    while (sb.ph == ST_SEND) begin
      if (!plain && $urandom_range(0, 9) == 0) push_rand(func_e'($urandom_range(0, 2)));
      else push_rand(FUNC_SLOT);
    end
  endtask

  task automatic answer_frame(bit plain);
    int         pick;
    int         n;
    logic [7:0] c;
    logic [7:0] k;
    logic [7:0] nm;
    if (!plain) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        n = $urandom_range(1, 4);
        repeat (n) if (sb.ph == ST_WAIT) push_rand(FUNC_TICK);
      end else if (pick < 40 && sb.timeout <= 20) begin
        while (sb.ph == ST_WAIT) push_rand(FUNC_TICK);
      end else if (pick < 45) begin
        push_rand(FUNC_SLOT);
      end
    end
    if (sb.ph != ST_WAIT) return;
    k    = KIND_ACK;
    nm   = sb.seq;
    pick = plain ? 99 : $urandom_range(0, 99);
    if (pick < 6) begin
      k = 8'($urandom);
      if (k == KIND_ACK) k = ~k;
      c = good_check(k, nm);
    end else if (pick < 12) begin
      nm = sb.seq + 8'($urandom_range(1, 255));
      c  = good_check(k, nm);
    end else if (pick < 18) begin
      c = 8'($urandom);
      while (sb.add_ec(sb.add_ec(c, k), nm) == SUM_GOOD) c = c + 8'd1;
    end else if (pick < 22) begin
      c  = 8'($urandom);
      k  = 8'($urandom);
      nm = 8'($urandom);
    end else begin
      c = good_check(k, nm);
    end
    push_item(FUNC_ACK, 8'($urandom), 1'($urandom_range(0, 1)), c, k, nm);
  endtask

  task automatic run_packet(int target, bit plain);
    load_packet(target, plain);
    while (sb.ph != ST_LOAD) begin
      send_frame(plain);
      answer_frame(plain);
    end
  endtask

  task automatic random_phase(int n);
    int goal;
    goal = items_sent + n;
    while (items_sent < goal)
      run_packet(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12),
                 1'b0);
  endtask

  initial begin : stimulus
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_DATA;
    s_axis_tlast  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_TIMEOUT;
    cfg_wdata_i   = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero limit behaves as one byte, zero timeout trips on the first tick
    write_cfg(16'd0, 14'd0);
    push_item(FUNC_ACK, 8'h00, 1'b1, 8'hFF, 8'hFF, 8'hFF);
    push_item(FUNC_TICK, 8'hFF, 1'b0, 8'h00, 8'h00, 8'h00);
    push_item(FUNC_SLOT, 8'h00, 1'b1, 8'hFF, 8'hFF, 8'hFF);
    push_item(FUNC_DATA, 8'hFF, 1'b0, 8'h00, 8'h00, 8'h00);
    push_item(FUNC_DATA, 8'h00, 1'b1, 8'hFF, 8'hFF, 8'hFF);  // dropped while sending
    send_frame(1'b1);
    push_item(FUNC_TICK, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00);
    send_frame(1'b1);
    // checksum fine but not an ACK flag
    push_item(FUNC_ACK, 8'h00, 1'b0, good_check(8'h07, 8'h00), 8'h07, 8'h00);
    send_frame(1'b1);
    push_item(FUNC_ACK, 8'hFF, 1'b1, good_check(KIND_ACK, 8'h00), KIND_ACK, 8'h00);
    // final packet carries the length byte
    push_item(FUNC_DATA, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00);
    send_frame(1'b1);
    push_item(FUNC_ACK, 8'h00, 1'b0, good_check(KIND_ACK, 8'h01), KIND_ACK, 8'h01);

    write_cfg(16'd2, 14'd3);
    random_phase(80);

    // short packets acked one after another
    write_cfg(16'd0, 14'd1);
    repeat (20) run_packet($urandom_range(1, 2), 1'b1);

    // oversized limit: packets close only on the last byte
    write_cfg(16'hFFFF, 14'h3FFF);
    random_phase(80);
    repeat (5) push_item(FUNC_DATA, 8'($urandom), 1'b0, 8'($urandom), 8'($urandom),
                         8'($urandom));

    // limit now below the bytes already held: next byte closes the packet
    write_cfg(16'd5, 14'd2);
    random_phase(80);

    // length byte keeps only the low eight bits of 258
    write_cfg(16'd1000, 14'd8192);
    run_packet(258, 1'b0);

    write_cfg(16'd1, 14'd7);
    no_idle = 1'b1;
    random_phase(80);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

/* sim.f */
hdl/sawfs_pkg.sv
hdl/sawfs_ram.sv
hdl/sawfs_front.sv
hdl/sawfs_back.sv
hdl/stop_and_wait_frame_sender_core.sv
tb/sv/tb_stop_and_wait_frame_sender_core.sv
